// ===== hdl/range_remap_splitter_macros.svh =====
// assertion macros for the range remap splitter
`ifndef RANGE_REMAP_SPLITTER_MACROS_SVH
`define RANGE_REMAP_SPLITTER_MACROS_SVH

// property that must hold on every clock edge outside reset
`define RRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next edge
`define RRS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/rrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// shared types and codes of the range remap splitter
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_CLEAR     = 2'd1;
    localparam logic [1:0] OP_TRANSLATE = 2'd2;
    localparam logic [1:0] OP_IGNORED   = 2'd3;

    localparam logic [2:0] ST_PIECE    = 3'd0;
    localparam logic [2:0] ST_LOADED   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;
    localparam logic [2:0] ST_BADRANGE = 3'd5;

    localparam int ADDR_BITS = 40;
    localparam int START_W   = ADDR_BITS;
    localparam int LEN_W     = ADDR_BITS + 1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [START_W-1:0] dest_base;
        logic [START_W-1:0] source_base;
        logic [LEN_W-1:0]   span;
    } req_t;

    typedef struct packed {
        logic [START_W-1:0] piece_start;
        logic [LEN_W-1:0]   piece_length;
        logic [2:0]         status;
        logic               last;
    } rsp_t;

    // one stored region; end is source plus length
    typedef struct packed {
        logic               valid;
        logic [START_W-1:0] dest;
        logic [START_W:0]   src;
        logic [START_W:0]   rend;
    } region_t;

    // control from the sequencer to the cells
    typedef struct packed {
        logic shift;
        logic insert;
        logic clear;
    } cell_ctl_t;

endpackage

// ===== hdl/rrs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface rrs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/range_remap_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_remap_splitter
// remaps address ranges through a sorted chain of region cells
// ----------------------------------------------------------------------------
// channel   dir  payload
// req       in   opcode, dest_base, source_base, span
// rsp       out  piece_start, piece_length, status, last
//
// a load or clear is taken into op_reg, checked in S_CHECK once rsp is free and answered
// from the output register; the next transfer can follow once that result is taken
// a translate rotates the table once round the chain, one cell per cycle while rsp
// is free and no gap piece is sent; the next transfer waits until the rotation ends
// reset empties the table at once; a piece held back on rsp holds the walk
`include "range_remap_splitter_macros.svh"

module range_remap_splitter
#(
    parameter int MAX_REGIONS = 16
)
(
    input logic clk,
    input logic rst_n,
    rrs_if.sink   req,
    rrs_if.source rsp
);

    localparam int SW = rrs_pkg::START_W;
    localparam int LW = rrs_pkg::LEN_W;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [SW:0] SPACE = (SW+1)'(1) << rrs_pkg::ADDR_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd4;

    logic [2:0]          state_reg, state_next;
    rrs_pkg::req_t       op_reg, op_next;
    logic [SW:0]         cur_reg, cur_next;
    logic [SW:0]         end_reg, end_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    rrs_pkg::rsp_t       out_reg, out_next;

    rrs_pkg::region_t    cells [MAX_REGIONS];
    rrs_pkg::region_t    new_region;
    rrs_pkg::cell_ctl_t  ctl;
    logic [MAX_REGIONS-1:0] take_new;
    logic [CW-1:0]       region_count;

    logic [SW:0] src_ext, dst_ext, in_end, dst_end;
    logic        src_fits, dst_fits, full;
    rrs_pkg::region_t head;
    logic        out_free;

    assign src_ext = {1'b0, op_reg.source_base};
    assign dst_ext = {1'b0, op_reg.dest_base};
    assign in_end  = src_ext + op_reg.span[SW:0];
    assign dst_end = dst_ext + op_reg.span[SW:0];
    assign src_fits = (op_reg.span != '0) && (op_reg.span <= SPACE) && (in_end <= SPACE);
    assign dst_fits = (op_reg.span != '0) && (op_reg.span <= SPACE) && (dst_end <= SPACE);

    always_comb
    begin
        region_count = '0;
        for (int i = 0; i < MAX_REGIONS; i++)
        begin
            region_count = region_count + CW'(cells[i].valid);
        end
    end
    assign full = (region_count == CW'(MAX_REGIONS));
    assign head = cells[MAX_REGIONS-1];

    // table kept in descending order so the rotation presents it ascending at the head
    // insertion slot: cell i takes the new region when it is empty or smaller and its predecessor is larger
    assign new_region.valid = 1'b1;
    assign new_region.dest  = op_reg.dest_base;
    assign new_region.src   = src_ext;
    assign new_region.rend  = in_end;

    always_comb
    begin
        take_new[0] = !cells[0].valid || (cells[0].src < src_ext);
        for (int i = 1; i < MAX_REGIONS; i++)
        begin
            take_new[i] = (!cells[i].valid || cells[i].src < src_ext)
                          && cells[i-1].valid && (cells[i-1].src > src_ext);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_REGIONS; g++)
        begin : g_cell
            rrs_pkg::region_t prev;
            rrs_pkg::cell_ctl_t cctl;
            if (g == 0)
            begin : g_first
                assign prev = cells[MAX_REGIONS-1];
            end
            else
            begin : g_rest
                assign prev = cells[g-1];
            end
            // on insert cells past the slot shift back by one
            always_comb
            begin
                cctl = ctl;
                if (ctl.insert)
                begin
                    cctl.shift = (g != 0) && !take_new[g] && (cells[g].valid || prev.valid)
                                 && !(prev.valid && prev.src > src_ext);
                    if (cctl.shift)
                    begin
                        cctl.insert = 1'b0;
                    end
                end
            end
            rrs_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (cctl),
                .take_new    (take_new[g]),
                .new_region  (new_region),
                .prev_region (prev),
                .region      (cells[g])
            );
        end
    endgenerate

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    function automatic rrs_pkg::rsp_t mk(input logic [SW:0] s, input logic [SW:0] l,
                                         input logic [2:0] st, input logic lst);
        rrs_pkg::rsp_t r;
        r.piece_start  = s[SW-1:0];
        r.piece_length = LW'(l);
        r.status       = st;
        r.last         = lst;
        return r;
    endfunction

    always_comb
    begin
        logic [SW:0] rs, re, lim;
        logic        active, ovl;
        state_next     = state_reg;
        op_next        = op_reg;
        cur_next       = cur_reg;
        end_next       = end_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        ctl            = '0;
        rs  = head.src;
        re  = head.rend;
        lim = (re < end_reg) ? re : end_reg;
        active = head.valid && (re > cur_reg) && (rs < end_reg);
        ovl = 1'b0;
        for (int i = 0; i < MAX_REGIONS; i++)
        begin
            ovl = ovl | (cells[i].valid && src_ext < cells[i].rend && cells[i].src < in_end);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    op_next = req.data;
                    if (req.data.opcode != rrs_pkg::OP_IGNORED)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    out_valid_next = 1'b1;
                    case (op_reg.opcode)
                        rrs_pkg::OP_LOAD:
                        begin
                            if (full)
                                out_next = mk('0, '0, rrs_pkg::ST_FULL, 1'b1);
                            else if (!src_fits || !dst_fits || ovl)
                                out_next = mk('0, '0, rrs_pkg::ST_NOSPACE, 1'b1);
                            else
                            begin
                                ctl.insert = 1'b1;
                                out_next = mk('0, '0, rrs_pkg::ST_LOADED, 1'b1);
                            end
                        end
                        rrs_pkg::OP_CLEAR:
                        begin
                            ctl.clear = 1'b1;
                            out_next = mk('0, '0, rrs_pkg::ST_CLEARED, 1'b1);
                        end
                        rrs_pkg::OP_TRANSLATE:
                        begin
                            if (!src_fits)
                                out_next = mk('0, '0, rrs_pkg::ST_BADRANGE, 1'b1);
                            else
                            begin
                                out_valid_next = 1'b0;
                                cur_next = src_ext;
                                end_next = in_end;
                                cnt_next = '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // head cell is region cnt; rotate one per cycle while rsp is free and no gap piece is sent
                if (out_free)
                begin
                    if (cnt_reg == CW'(MAX_REGIONS))
                    begin
                        state_next = S_IDLE;
                        out_valid_next = 1'b1;
                        out_next = mk(cur_reg, end_reg - cur_reg, rrs_pkg::ST_PIECE, 1'b1);
                    end
                    else if (active && rs > cur_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next = mk(cur_reg, rs - cur_reg, rrs_pkg::ST_PIECE, 1'b0);
                        cur_next = rs;
                    end
                    else
                    begin
                        ctl.shift = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                        if (active)
                        begin
                            out_valid_next = 1'b1;
                            out_next = mk(cur_reg - rs + {1'b0, head.dest}, lim - cur_reg,
                                          rrs_pkg::ST_PIECE, lim == end_reg);
                            cur_next = lim;
                            if (lim == end_reg)
                            begin
                                state_next = S_TAIL;
                            end
                        end
                    end
                end
            end
            S_TAIL:
            begin
                // finish the rotation so the table order is restored
                ctl.shift = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MAX_REGIONS))
                begin
                    ctl.shift = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cur_reg  <= cur_next;
        end_reg  <= end_next;
        out_reg  <= out_next;
    end

    `RRS_ASSERT(a_no_accept_busy, !(req.valid && req.ready && state_reg != S_IDLE), "busy accept")
    `RRS_ASSERT(a_count_range, region_count <= CW'(MAX_REGIONS), "region count too large")
    `RRS_ASSERT_NEXT(a_hold, rsp.valid && !rsp.ready, rsp.valid, "result dropped")

endmodule

// ===== hdl/rrs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_cell
// one table slot; shifts towards the head cell on insert, rotates for a walk or
// empties on clear
module rrs_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  rrs_pkg::cell_ctl_t ctl,
    input  logic               take_new,
    input  rrs_pkg::region_t   new_region,
    input  rrs_pkg::region_t   prev_region,
    output rrs_pkg::region_t   region
);

    logic             valid_reg;
    rrs_pkg::region_t data_reg;
    rrs_pkg::region_t region_next;

    always_comb
    begin
        region       = data_reg;
        region.valid = valid_reg;
    end

    always_comb
    begin
        region_next = region;
        if (ctl.clear)
        begin
            region_next.valid = 1'b0;
        end
        else if (ctl.shift)
        begin
            region_next = prev_region;
        end
        else if (ctl.insert && take_new)
        begin
            region_next = new_region;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= region_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= region_next;
    end

endmodule

// ===== dv/range_remap_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_remap_splitter_tb
// drives loads, clears, translates and ignored requests into the region
// table with random gaps and output stalls; a scoreboard keeps its own region
// table and checks every returned piece or status against the expected sequence
// ----------------------------------------------------------------------------
module range_remap_splitter_tb;

    localparam int NREG = 16;
    localparam logic [rrs_pkg::LEN_W-1:0] SPACE = 41'h100_0000_0000;

    logic clk;
    logic rst_n;
    int   cycles;
    bit   timed_out;
    bit   calm;

    rrs_if #(.T(rrs_pkg::req_t)) req ();
    rrs_if #(.T(rrs_pkg::rsp_t)) rsp ();

    range_remap_splitter #(.MAX_REGIONS(NREG)) i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    class remap_scoreboard;
        logic [rrs_pkg::START_W-1:0] dst_tab [NREG];
        logic [rrs_pkg::LEN_W-1:0]   src_tab [NREG];
        logic [rrs_pkg::LEN_W-1:0]   len_tab [NREG];
        int                          count;
        rrs_pkg::rsp_t               pending [$];
        int                          errors;

        function bit fits(logic [rrs_pkg::LEN_W-1:0] base, logic [rrs_pkg::LEN_W-1:0] len);
            return len != 0 && len <= SPACE && base < SPACE && len <= SPACE - base;
        endfunction

        function void push(logic [rrs_pkg::START_W-1:0] s, logic [rrs_pkg::LEN_W-1:0] l,
                           logic [2:0] st);
            rrs_pkg::rsp_t r;
            r.piece_start  = s;
            r.piece_length = l;
            r.status       = st;
            r.last         = 1'b0;
            pending.insert(pending.size(), r);
        endfunction

        function logic [2:0] load(rrs_pkg::req_t q);
            int pos;
            if (count >= NREG)
                return rrs_pkg::ST_FULL;
            if (!fits(q.source_base, q.span) || !fits(q.dest_base, q.span))
                return rrs_pkg::ST_NOSPACE;
            for (int i = 0; i < count; i++)
                if (q.source_base < src_tab[i] + len_tab[i] &&
                    src_tab[i] < q.source_base + q.span)
                    return rrs_pkg::ST_NOSPACE;
            pos = 0;
            while (pos < count && src_tab[pos] < q.source_base)
                pos++;
            for (int i = count; i > pos; i--)
            begin
                dst_tab[i] = dst_tab[i-1];
                src_tab[i] = src_tab[i-1];
                len_tab[i] = len_tab[i-1];
            end
            dst_tab[pos] = q.dest_base;
            src_tab[pos] = q.source_base;
            len_tab[pos] = q.span;
            count++;
            return rrs_pkg::ST_LOADED;
        endfunction

        function void note_request(rrs_pkg::req_t q);
            logic [rrs_pkg::LEN_W-1:0] cur, stop, rs, re, lim;
            int first;
            first = pending.size();
            case (q.opcode)
                rrs_pkg::OP_LOAD:  push('0, '0, load(q));
                rrs_pkg::OP_CLEAR:
                begin
                    count = 0;
                    push('0, '0, rrs_pkg::ST_CLEARED);
                end
                rrs_pkg::OP_TRANSLATE:
                begin
                    if (!fits(q.source_base, q.span))
                        push('0, '0, rrs_pkg::ST_BADRANGE);
                    else
                    begin
                        cur  = q.source_base;
                        stop = q.source_base + q.span;
                        for (int i = 0; i < count; i++)
                        begin
                            rs = src_tab[i];
                            re = rs + len_tab[i];
                            if (re <= cur)
                                continue;
                            if (rs >= stop)
                                break;
                            if (rs > cur)
                            begin
                                push(cur[rrs_pkg::START_W-1:0], rs - cur, rrs_pkg::ST_PIECE);
                                cur = rs;
                            end
                            lim = (re < stop) ? re : stop;
                            push(rrs_pkg::START_W'(cur - rs + dst_tab[i]), lim - cur,
                                 rrs_pkg::ST_PIECE);
                            cur = lim;
                        end
                        if (cur < stop)
                            push(cur[rrs_pkg::START_W-1:0], stop - cur, rrs_pkg::ST_PIECE);
                    end
                end
                default: ;
            endcase
            if (pending.size() > first)
                pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_result(rrs_pkg::rsp_t got);
            rrs_pkg::rsp_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    remap_scoreboard sb;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.data);
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(rsp.data);
    end

    // output stalls
    always @(posedge clk)
        rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);

    task automatic send(logic [1:0] op, logic [rrs_pkg::START_W-1:0] d,
                        logic [rrs_pkg::START_W-1:0] s, logic [rrs_pkg::LEN_W-1:0] l);
        rrs_pkg::req_t q;
        q.opcode      = op;
        q.dest_base   = d;
        q.source_base = s;
        q.span        = l;
        while (!calm && $urandom_range(99) < 17)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= q;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    function automatic logic [rrs_pkg::START_W-1:0] rand_addr();
        return rrs_pkg::START_W'({$urandom, $urandom});
    endfunction

    function automatic logic [rrs_pkg::START_W-1:0] small_addr();
        return rrs_pkg::START_W'($urandom_range(4095));
    endfunction

    task automatic random_phase(int n, bit wide);
        int op;
        logic [rrs_pkg::START_W-1:0] d, s;
        logic [rrs_pkg::LEN_W-1:0]   l;
        for (int k = 0; k < n; k++)
        begin
            op = $urandom_range(99);
            d  = wide ? rand_addr() : small_addr();
            s  = wide ? rand_addr() : small_addr();
            l  = rrs_pkg::LEN_W'($urandom_range(wide ? 32'hffff_ffff : 600, 0));
            if ($urandom_range(9) == 0)
                l = rrs_pkg::LEN_W'({$urandom, $urandom});
            if (op < 40)
                send(rrs_pkg::OP_LOAD, d, s, l);
            else if (op < 44)
                send(rrs_pkg::OP_CLEAR, d, s, l);
            else if (op < 97)
                send(rrs_pkg::OP_TRANSLATE, d, s, l);
            else
                send(rrs_pkg::OP_IGNORED, d, s, l);
        end
    endtask

    initial
    begin
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        cycles    = 0;
        timed_out = 1'b0;
        calm      = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        rsp.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send(rrs_pkg::OP_TRANSLATE, '0, '0, 41'd1);
        send(rrs_pkg::OP_TRANSLATE, '0, '0, SPACE);
        send(rrs_pkg::OP_TRANSLATE, '0, 40'hff_ffff_ffff, 41'd1);
        send(rrs_pkg::OP_TRANSLATE, '0, 40'hff_ffff_ffff, 41'd2);
        send(rrs_pkg::OP_TRANSLATE, '0, 40'd5, '0);
        send(rrs_pkg::OP_LOAD, 40'd1000, 40'd100, 41'd50);
        send(rrs_pkg::OP_LOAD, 40'd7, 40'd120, 41'd50);
        send(rrs_pkg::OP_LOAD, 40'd7, 40'd10, '0);
        send(rrs_pkg::OP_LOAD, 40'hff_ffff_ffff, 40'd300, 41'd2);
        send(rrs_pkg::OP_LOAD, 40'd0, 40'hff_ffff_ffff, 41'd1);
        send(rrs_pkg::OP_LOAD, 40'hff_ffff_fff0, 40'd0, 41'd16);
        send(rrs_pkg::OP_TRANSLATE, '0, '0, SPACE);
        send(rrs_pkg::OP_TRANSLATE, '0, 40'd110, 41'd20);
        send(rrs_pkg::OP_IGNORED, 40'hff_ffff_ffff, 40'hff_ffff_ffff, 41'h1ff_ffff_ffff);
        send(rrs_pkg::OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < 17; i++)
            send(rrs_pkg::OP_LOAD, 40'hff_ffff_ff00 - 40'(i * 64), 40'(i * 64 + 8), 41'd32);
        send(rrs_pkg::OP_TRANSLATE, '0, '0, SPACE);

        random_phase(180, 1'b0);
        calm = 1'b1;
        random_phase(60, 1'b0);
        calm = 1'b0;
        send(rrs_pkg::OP_CLEAR, '0, '0, '0);
        random_phase(140, 1'b1);
        req.valid <= 1'b0;

        while (sb.pending.size() != 0 && cycles < 200000)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[range_remap_splitter] OK");
        else
            $display("[range_remap_splitter] ERROR");
        $finish;
    end

    always @(posedge clk)
        if (cycles > 400000 && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("[range_remap_splitter] ERROR");
            $finish;
        end

endmodule
